// ===== hw/rtl/msma_pkg.sv =====
// ----------------------------------------------------------------------------
// msma_pkg
// Shared types and constants for the sign-magnitude word arithmetic unit.
// ----------------------------------------------------------------------------
package msma_pkg;

  localparam int unsigned MagBits  = 30;
  localparam int unsigned WordBits = MagBits + 1;
  localparam int unsigned CntBits  = $clog2(MagBits);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } msma_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_DIV_END,
    ST_OUT
  } msma_state_e;

  typedef struct packed {
    msma_op_e              operation;
    logic [WordBits-1:0]   word_x;
    logic [WordBits-1:0]   word_y;
    logic [WordBits-1:0]   word_low;
    logic                  clear_overflow;
  } msma_in_t;

  typedef struct packed {
    logic [WordBits-1:0]   result_first;
    logic [WordBits-1:0]   result_second;
    logic                  overflow_now;
    logic                  overflow_sticky;
  } msma_out_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic div_step;
    logic div_end;
    logic publish;
  } msma_cmd_t;

  typedef struct packed {
    msma_op_e op;
    logic     div_bad;
  } msma_status_t;

endpackage

// ===== hw/rtl/msma_dp.sv =====
// ----------------------------------------------------------------------------
// msma_dp
// Datapath: operand registers, adder, multiplier, restoring divider step,
// result registers, output word register and sticky overflow flag.
// ----------------------------------------------------------------------------
module msma_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  msma_pkg::msma_in_t    in_word_i,
  input  msma_pkg::msma_cmd_t   cmd_i,
  output msma_pkg::msma_status_t status_o,
  output msma_pkg::msma_out_t   out_word_o
);

  localparam int unsigned MB = msma_pkg::MagBits;
  localparam int unsigned WB = msma_pkg::WordBits;

  msma_pkg::msma_op_e op_q;
  logic               sx_q, sy_q, clr_q;
  logic [MB-1:0]      mx_q, my_q;
  logic [MB-1:0]      rem_q, rem_d;
  logic [MB-1:0]      quo_q, quo_d;
  logic [WB-1:0]      res_first_q, res_first_d;
  logic [WB-1:0]      res_second_q, res_second_d;
  logic               ovf_res_q, ovf_res_d;
  logic               flag_q, sticky_d;
  msma_pkg::msma_out_t out_q;

  logic               sy_eff;
  logic [MB:0]        sum;
  logic [2*MB-1:0]    prod;
  logic [MB:0]        trial, diff;
  logic               ge;
  logic               div_bad;

  assign div_bad = (my_q == '0) || (my_q <= mx_q);
  assign status_o.op      = op_q;
  assign status_o.div_bad = div_bad;

  // add, subtract, multiply and divide early exit
  always_comb begin
    sy_eff       = sy_q ^ (op_q == msma_pkg::OP_SUB);
    sum          = {1'b0, mx_q} + {1'b0, my_q};
    prod         = {{MB{1'b0}}, mx_q} * {{MB{1'b0}}, my_q};
    res_first_d  = res_first_q;
    res_second_d = res_second_q;
    ovf_res_d    = ovf_res_q;
    if (cmd_i.exec) begin
      unique case (op_q)
        msma_pkg::OP_ADD, msma_pkg::OP_SUB: begin
          res_second_d = '0;
          ovf_res_d    = 1'b0;
          if (sx_q == sy_eff) begin
            res_first_d = {sx_q, sum[MB-1:0]};
            ovf_res_d   = sum[MB];
          end else if (mx_q < my_q) begin
            res_first_d = {sy_eff, my_q - mx_q};
          end else begin
            res_first_d = {sx_q, mx_q - my_q};
          end
        end
        msma_pkg::OP_MUL: begin
          res_first_d  = {sx_q ^ sy_q, prod[2*MB-1:MB]};
          res_second_d = {sx_q ^ sy_q, prod[MB-1:0]};
          ovf_res_d    = 1'b0;
        end
        msma_pkg::OP_DIV: begin
          res_first_d  = '0;
          res_second_d = '0;
          ovf_res_d    = 1'b1;
        end
        default: begin
          ovf_res_d = ovf_res_q;
        end
      endcase
    end else if (cmd_i.div_end) begin
      res_first_d  = {sx_q ^ sy_q, quo_q};
      res_second_d = {sx_q, rem_q};
      ovf_res_d    = 1'b0;
    end
  end

  // one quotient bit per step
  always_comb begin
    trial = {rem_q, quo_q[MB-1]};
    diff  = trial - {1'b0, my_q};
    ge    = trial >= {1'b0, my_q};
    rem_d = ge ? diff[MB-1:0] : trial[MB-1:0];
    quo_d = {quo_q[MB-2:0], ge};
  end

  assign sticky_d = (flag_q & ~clr_q) | ovf_res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_word_i.operation;
      sx_q  <= in_word_i.word_x[MB];
      sy_q  <= in_word_i.word_y[MB];
      mx_q  <= in_word_i.word_x[MB-1:0];
      my_q  <= in_word_i.word_y[MB-1:0];
      clr_q <= in_word_i.clear_overflow;
      rem_q <= in_word_i.word_x[MB-1:0];
      quo_q <= in_word_i.word_low[MB-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    res_first_q  <= res_first_d;
    res_second_q <= res_second_d;
    ovf_res_q    <= ovf_res_d;
    if (cmd_i.publish) begin
      out_q.result_first    <= res_first_q;
      out_q.result_second   <= res_second_q;
      out_q.overflow_now    <= ovf_res_q;
      out_q.overflow_sticky <= sticky_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else if (cmd_i.publish) begin
      flag_q <= sticky_d;
    end
  end

  assign out_word_o = out_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < my_q))
    else $error("partial remainder not below divisor");

  a_mul_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && op_q == msma_pkg::OP_MUL) |=> !ovf_res_q)
    else $error("multiply raised overflow");

endmodule

// ===== hw/rtl/msma_ctrl.sv =====
// ----------------------------------------------------------------------------
// msma_ctrl
// Controller: sequences load, execute, divide steps and output hand-off,
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module msma_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  msma_pkg::msma_status_t status_i,
  output msma_pkg::msma_cmd_t    cmd_o
);

  localparam int unsigned CB = msma_pkg::CntBits;
  localparam logic [CB-1:0] LastStep = CB'(msma_pkg::MagBits - 1);

  msma_pkg::msma_state_e state_q, state_d;
  logic [CB-1:0]         cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msma_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      msma_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = msma_pkg::ST_EXEC;
        end
      end
      msma_pkg::ST_EXEC: begin
        if (status_i.op == msma_pkg::OP_DIV && !status_i.div_bad) begin
          cnt_d   = '0;
          state_d = msma_pkg::ST_DIV;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = msma_pkg::ST_OUT;
        end
      end
      msma_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == LastStep) begin
          state_d = msma_pkg::ST_DIV_END;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      msma_pkg::ST_DIV_END: begin
        cmd_o.div_end = 1'b1;
        state_d       = msma_pkg::ST_OUT;
      end
      msma_pkg::ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.publish = 1'b1;
          state_d       = msma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = msma_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign in_stall_o  = (state_q != msma_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> (!out_valid_q || !out_stall_i))
    else $error("output word overwritten while stalled");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == msma_pkg::ST_DIV && cnt_q == LastStep) |=>
      (state_q == msma_pkg::ST_DIV_END))
    else $error("divide loop did not end after last step");

  a_load_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == msma_pkg::ST_EXEC))
    else $error("load not followed by execute");

endmodule

// ===== hw/rtl/mix_sign_magnitude_alu.sv =====
// ----------------------------------------------------------------------------
// mix_sign_magnitude_alu
// Sign-magnitude word arithmetic unit: add, subtract, multiply, divide.
// ----------------------------------------------------------------------------
// latency accept to output valid: load, execute and publish for add, subtract,
// multiply and rejected divide; divide: load, execute, 30 restoring steps (one
// bit a cycle), divide end and publish; one word in flight until published
// output register lets a new word start while the last result is stalled
// reset clears the controller, the output valid flag and sticky overflow
module mix_sign_magnitude_alu (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  msma_pkg::msma_in_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output msma_pkg::msma_out_t out_word_o
);

  msma_pkg::msma_cmd_t    cmd;
  msma_pkg::msma_status_t status;

  msma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  msma_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_word_o (out_word_o)
  );

endmodule

// ===== tb/sv/mix_sign_magnitude_alu_tb.sv =====
// ----------------------------------------------------------------------------
// mix_sign_magnitude_alu_tb
// Self-checking bench for the sign-magnitude word arithmetic unit. A short
// table of hand-picked words covers the extremes, every operation, signed
// zero, wrap-around overflow and the rejected divides. Random words follow.
// Each accepted word is run through a local model of the unit, but a fixed
// row's own word is expected instead; each output word is checked in order.
// Both sides idle at random; one long receiver stall makes the input back up.
// ----------------------------------------------------------------------------
module mix_sign_magnitude_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import msma_pkg::*;

  localparam int unsigned WideBits    = 2 * MagBits;
  localparam int unsigned RandomWords = 1250;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned DrainCycles = 40;
  localparam logic [MagBits-1:0]  MagMax   = '1;
  localparam logic [WordBits-1:0] SignMask = {1'b1, {MagBits{1'b0}}};

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_HEAVY
  } stall_mode_e;

  typedef struct packed {
    msma_in_t  word;
    logic      fixed;
    msma_out_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall_o;
  msma_in_t  in_word;
  logic      out_valid_o;
  logic      out_stall;
  msma_out_t out_word_o;

  logic      row_fixed;
  msma_out_t row_want;

  logic        sticky_ovf;
  msma_out_t   pending_results[$];
  int unsigned n_errors;
  int unsigned n_words;
  int unsigned n_by_op[4];
  int unsigned n_div_reject;
  int unsigned n_ovf;
  int unsigned n_in_stalled;

  mix_sign_magnitude_alu u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_word_o  (out_word_o)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [WordBits-1:0] sm(input logic s, input logic [MagBits-1:0] m);
    return {s, m};
  endfunction

  function automatic msma_out_t res_of(input logic [WordBits-1:0] first,
                                       input logic [WordBits-1:0] second,
                                       input logic ovf_now, input logic ovf_sticky);
    msma_out_t r;
    r.result_first    = first;
    r.result_second   = second;
    r.overflow_now    = ovf_now;
    r.overflow_sticky = ovf_sticky;
    return r;
  endfunction

  function automatic stim_row_t row(input msma_op_e op, input logic [WordBits-1:0] x,
                                    input logic [WordBits-1:0] y,
                                    input logic [WordBits-1:0] lo, input logic clr,
                                    input logic fixed, input msma_out_t want);
    stim_row_t r;
    r.word.operation      = op;
    r.word.word_x         = x;
    r.word.word_y         = y;
    r.word.word_low       = lo;
    r.word.clear_overflow = clr;
    r.fixed               = fixed;
    r.want                = want;
    return r;
  endfunction

  // sign-magnitude add, carry out of the magnitude flagged
  function automatic logic [WordBits-1:0] add_sm(input logic [WordBits-1:0] a,
                                                 input logic [WordBits-1:0] b,
                                                 output logic carry);
    logic [MagBits:0]   sum;
    logic [MagBits-1:0] ma;
    logic [MagBits-1:0] mb;
    ma    = a[MagBits-1:0];
    mb    = b[MagBits-1:0];
    carry = 1'b0;
    if (a[MagBits] == b[MagBits]) begin
      sum   = {1'b0, ma} + {1'b0, mb};
      carry = sum[MagBits];
      return {a[MagBits], sum[MagBits-1:0]};
    end
    if (ma < mb) return {b[MagBits], mb - ma};
    return {a[MagBits], ma - mb};
  endfunction

  function automatic msma_out_t compute_mix_result(input msma_in_t w);
    msma_out_t          r;
    logic               ovf;
    logic               sgn;
    logic [WideBits-1:0] wide;
    logic [WideBits-1:0] quo;
    logic [WideBits-1:0] rem;
    logic [MagBits-1:0] mhi;
    logic [MagBits-1:0] md;
    r   = '0;
    ovf = 1'b0;
    if (w.clear_overflow) sticky_ovf = 1'b0;
    case (w.operation)
      OP_ADD: r.result_first = add_sm(w.word_x, w.word_y, ovf);
      OP_SUB: r.result_first = add_sm(w.word_x, w.word_y ^ SignMask, ovf);
      OP_MUL: begin
        sgn  = w.word_x[MagBits] ^ w.word_y[MagBits];
        wide = WideBits'(w.word_x[MagBits-1:0]) * WideBits'(w.word_y[MagBits-1:0]);
        r.result_first  = {sgn, wide[WideBits-1:MagBits]};
        r.result_second = {sgn, wide[MagBits-1:0]};
      end
      OP_DIV: begin
        mhi = w.word_x[MagBits-1:0];
        md  = w.word_y[MagBits-1:0];
        if (md == '0 || md <= mhi) begin
          ovf = 1'b1;
        end else begin
          wide = {mhi, w.word_low[MagBits-1:0]};
          quo  = wide / WideBits'(md);
          rem  = wide % WideBits'(md);
          r.result_first  = {w.word_x[MagBits] ^ w.word_y[MagBits], quo[MagBits-1:0]};
          r.result_second = {w.word_x[MagBits], rem[MagBits-1:0]};
        end
      end
    endcase
    if (ovf) sticky_ovf = 1'b1;
    r.overflow_now    = ovf;
    r.overflow_sticky = sticky_ovf;
    return r;
  endfunction

  function automatic logic [MagBits-1:0] rand_mag();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return MagMax;
      2: return MagBits'($urandom_range(0, 15));
      3: return MagMax - MagBits'($urandom_range(0, 15));
      4: return MagBits'(1) << $urandom_range(0, MagBits - 1);
      default: return MagBits'($urandom);
    endcase
  endfunction

  function automatic msma_in_t random_mix_word();
    msma_in_t           w;
    logic [MagBits-1:0] md;
    w.operation      = msma_op_e'($urandom_range(0, 3));
    w.word_x         = {1'($urandom_range(0, 1)), rand_mag()};
    w.word_y         = {1'($urandom_range(0, 1)), rand_mag()};
    w.word_low       = WordBits'($urandom);
    w.clear_overflow = ($urandom_range(0, 7) == 0);
    // mostly divides that go through, with random content
    if (w.operation == OP_DIV && $urandom_range(0, 3) != 0) begin
      md = rand_mag();
      if (md == '0) md = MagBits'(1);
      w.word_y[MagBits-1:0] = md;
      w.word_x[MagBits-1:0] = ($urandom_range(0, 3) == 0) ? md - MagBits'(1)
                                                          : MagBits'($urandom % md);
    end
    return w;
  endfunction

  always @(posedge clk) begin : scoreboard
    msma_out_t want;
    msma_out_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        got = out_word_o;
        if (pending_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("%0t: unexpected word first=%h second=%h ovf=%b sticky=%b", $realtime,
                     got.result_first, got.result_second, got.overflow_now,
                     got.overflow_sticky);
        end else begin
          want = pending_results.pop_front();
          if (got.result_first !== want.result_first ||
              got.result_second !== want.result_second ||
              got.overflow_now !== want.overflow_now ||
              got.overflow_sticky !== want.overflow_sticky) begin
            n_errors++;
            if (n_errors <= 10)
              $display("%0t: mismatch first %h/%h second %h/%h ovf %b/%b sticky %b/%b",
                       $realtime, want.result_first, got.result_first,
                       want.result_second, got.result_second, want.overflow_now,
                       got.overflow_now, want.overflow_sticky, got.overflow_sticky);
          end
        end
      end
      if (in_valid && in_stall_o) n_in_stalled++;
      if (in_valid && !in_stall_o) begin
        want = compute_mix_result(in_word);
        n_words++;
        n_by_op[in_word.operation]++;
        if (want.overflow_now) n_ovf++;
        if (want.overflow_now && in_word.operation == OP_DIV) n_div_reject++;
        if (row_fixed) want = row_want;
        pending_results.push_back(want);
      end
    end
  end

  initial begin : receiver
    stall_mode_e mode;
    int unsigned len;
    int unsigned cycles;
    bit          held;
    out_stall = 1'b0;
    cycles    = 0;
    held      = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = stall_mode_e'($urandom_range(0, 3));
      len  = $urandom_range(4, 48);
      repeat (len) begin
        @(posedge clk);
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HALF:  out_stall <= 1'($urandom_range(0, 1));
          STALL_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
      end
      cycles += len;
      // one long back-pressure stretch while the sender keeps offering
      if (!held && cycles > 3000) begin
        @(posedge clk);
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
        held = 1'b1;
      end
    end
  end

  initial begin : sender
    stim_row_t   rows[$];
    stim_row_t   r;
    int unsigned burst_left;
    int unsigned gap;
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_word      = '0;
    row_fixed    = 1'b0;
    row_want     = '0;
    sticky_ovf   = 1'b0;
    n_errors     = 0;
    n_words      = 0;
    n_by_op      = '{default: 0};
    n_div_reject = 0;
    n_ovf        = 0;
    n_in_stalled = 0;

    rows.push_back(row(OP_ADD, sm(0, 0), sm(0, 0), '0, 0, 1,
                       res_of(sm(0, 0), sm(0, 0), 0, 0)));
    rows.push_back(row(OP_ADD, sm(0, MagMax), sm(0, 1), '0, 0, 1,
                       res_of(sm(0, 0), sm(0, 0), 1, 1)));
    rows.push_back(row(OP_ADD, sm(1, MagMax), sm(1, MagMax), '0, 0, 1,
                       res_of(sm(1, MagMax - 1), sm(0, 0), 1, 1)));
    rows.push_back(row(OP_ADD, sm(0, 5), sm(1, 5), '0, 1, 1,
                       res_of(sm(0, 0), sm(0, 0), 0, 0)));
    rows.push_back(row(OP_ADD, sm(1, 5), sm(0, 5), '1, 0, 1,
                       res_of(sm(1, 0), sm(0, 0), 0, 0)));
    rows.push_back(row(OP_ADD, sm(0, 3), sm(1, 10), '0, 0, 0, '0));
    rows.push_back(row(OP_SUB, sm(0, MagMax), sm(1, MagMax), '0, 0, 0, '0));
    rows.push_back(row(OP_SUB, sm(0, 7), sm(0, 7), '0, 0, 0, '0));
    rows.push_back(row(OP_SUB, sm(1, 0), sm(0, 0), '1, 0, 0, '0));
    rows.push_back(row(OP_SUB, sm(1, MagMax), sm(1, 1), '0, 0, 0, '0));
    rows.push_back(row(OP_MUL, sm(0, MagMax), sm(0, MagMax), '0, 1, 0, '0));
    rows.push_back(row(OP_MUL, sm(1, MagMax), sm(0, MagMax), '1, 0, 0, '0));
    rows.push_back(row(OP_MUL, sm(1, 0), sm(0, 5), '0, 1, 1,
                       res_of(sm(1, 0), sm(1, 0), 0, 0)));
    rows.push_back(row(OP_MUL, sm(0, 1), sm(1, MagMax), '0, 0, 0, '0));
    rows.push_back(row(OP_MUL, sm(0, 0), sm(0, 0), '1, 0, 1,
                       res_of(sm(0, 0), sm(0, 0), 0, 0)));
    rows.push_back(row(OP_DIV, sm(0, 1), sm(0, 0), sm(0, 7), 0, 1,
                       res_of(sm(0, 0), sm(0, 0), 1, 1)));
    rows.push_back(row(OP_DIV, sm(1, 0), sm(1, 0), '1, 1, 1,
                       res_of(sm(0, 0), sm(0, 0), 1, 1)));
    rows.push_back(row(OP_DIV, sm(0, 5), sm(1, 5), sm(0, 9), 1, 1,
                       res_of(sm(0, 0), sm(0, 0), 1, 1)));
    rows.push_back(row(OP_DIV, sm(1, MagMax), sm(0, MagMax), sm(0, MagMax), 0, 1,
                       res_of(sm(0, 0), sm(0, 0), 1, 1)));
    rows.push_back(row(OP_DIV, sm(0, MagMax - 1), sm(0, MagMax), '1, 1, 0, '0));
    rows.push_back(row(OP_DIV, sm(1, 0), sm(0, 1), sm(0, MagMax), 0, 0, '0));
    rows.push_back(row(OP_DIV, sm(0, 0), sm(1, 3), sm(1, 100), 0, 0, '0));
    rows.push_back(row(OP_DIV, sm(1, 2), sm(1, 7), sm(0, 30'h12345678), 0, 0, '0));
    rows.push_back(row(OP_ADD, sm(0, 1), sm(0, 1), '0, 1, 1,
                       res_of(sm(0, 2), sm(0, 0), 0, 0)));

    repeat (4) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    burst_left = 0;
    for (int i = 0; i < rows.size() + RandomWords; i++) begin
      if (i < rows.size()) begin
        r = rows[i];
      end else begin
        r.word  = random_mix_word();
        r.fixed = 1'b0;
        r.want  = '0;
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      in_valid  <= 1'b1;
      in_word   <= r.word;
      row_fixed <= r.fixed;
      row_want  <= r.want;
      @(posedge clk);
      while (in_stall_o !== 1'b0) @(posedge clk);
      burst_left--;
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    n_errors += pending_results.size();

    $display("run covered %0d words: %0d add, %0d sub, %0d mul, %0d div", n_words,
             n_by_op[OP_ADD], n_by_op[OP_SUB], n_by_op[OP_MUL], n_by_op[OP_DIV]);
    $display("%0d overflows, %0d rejected divides, %0d cycles of input back-pressure",
             n_ovf, n_div_reject, n_in_stalled);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/msma_pkg.sv
hw/rtl/msma_dp.sv
hw/rtl/msma_ctrl.sv
hw/rtl/mix_sign_magnitude_alu.sv
tb/sv/mix_sign_magnitude_alu_tb.sv
